// ===== hw/rtl/gtl_pkg.sv =====
package gtl_pkg;

   localparam int FIRST_MAPPED  = 182;
   localparam int TABLE_ROWS    = 73;
   localparam int CHARS_PER_ROW = 3;
   localparam int ITEM_CHARS    = CHARS_PER_ROW + 1;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
   localparam int ROW_W         = 7;
   localparam int IDX_W         = $clog2(ITEM_CHARS);
   localparam int CNT_W         = $clog2(ITEM_CHARS + 1);
   localparam int MCNT_W        = $clog2(CHARS_PER_ROW + 1);

   localparam logic [7:0] NUL   = 8'h00;
   localparam logic [7:0] CAP_M = 8'd204;
   localparam logic [7:0] CAP_N = 8'd205;
   localparam logic [7:0] CAP_P = 8'd208;
   localparam logic [7:0] CAP_T = 8'd212;
   localparam logic [7:0] SML_M = 8'd236;
   localparam logic [7:0] SML_N = 8'd237;
   localparam logic [7:0] SML_P = 8'd240;
   localparam logic [7:0] SML_T = 8'd244;

   typedef logic [CHARS_PER_ROW-1:0][7:0] row_type;

   typedef struct packed {
      row_type             chars;
      logic [MCNT_W-1:0]   cnt;
   } map_type;

   // One queued item: its output characters in order, chars[0] first.
   typedef struct packed {
      logic [ITEM_CHARS-1:0][7:0] chars;
      logic [CNT_W-1:0]           cnt;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

   function automatic row_type mk(input logic [7:0] c0, input logic [7:0] c1,
                                  input logic [7:0] c2);
      return {c2, c1, c0};
   endfunction

   function automatic row_type row_chars(input logic [ROW_W-1:0] row);
      row_type r;
      case (row)
         7'd0:    r = mk("'", "A", NUL);
         7'd2:    r = mk("'", "E", NUL);
         7'd3:    r = mk("'", "H", NUL);
         7'd4:    r = mk("'", "I", NUL);
         7'd6:    r = mk("'", "O", NUL);
         7'd8:    r = mk("'", "Y", NUL);
         7'd9:    r = mk("'", "W", NUL);
         7'd10:   r = mk("i", "\"", "'");
         7'd11:   r = mk("A", NUL, NUL);
         7'd12:   r = mk("V", NUL, NUL);
         7'd13:   r = mk("G", NUL, NUL);
         7'd14:   r = mk("D", NUL, NUL);
         7'd15:   r = mk("E", NUL, NUL);
         7'd16:   r = mk("Z", NUL, NUL);
         7'd17:   r = mk("H", NUL, NUL);
         7'd18:   r = mk("8", NUL, NUL);
         7'd19:   r = mk("I", NUL, NUL);
         7'd20:   r = mk("K", NUL, NUL);
         7'd21:   r = mk("L", NUL, NUL);
         7'd22:   r = mk("M", NUL, NUL);
         7'd23:   r = mk("N", NUL, NUL);
         7'd24:   r = mk("K", "S", NUL);
         7'd25:   r = mk("O", NUL, NUL);
         7'd26:   r = mk("P", NUL, NUL);
         7'd27:   r = mk("R", NUL, NUL);
         7'd29:   r = mk("S", NUL, NUL);
         7'd30:   r = mk("T", NUL, NUL);
         7'd31:   r = mk("Y", NUL, NUL);
         7'd32:   r = mk("F", NUL, NUL);
         7'd33:   r = mk("X", NUL, NUL);
         7'd34:   r = mk("P", "S", NUL);
         7'd35:   r = mk("W", NUL, NUL);
         7'd38:   r = mk("a", "'", NUL);
         7'd39:   r = mk("e", "'", NUL);
         7'd40:   r = mk("h", "'", NUL);
         7'd41:   r = mk("i", "'", NUL);
         7'd42:   r = mk("u", "\"", "'");
         7'd43:   r = mk("a", NUL, NUL);
         7'd44:   r = mk("v", NUL, NUL);
         7'd45:   r = mk("g", NUL, NUL);
         7'd46:   r = mk("d", NUL, NUL);
         7'd47:   r = mk("e", NUL, NUL);
         7'd48:   r = mk("z", NUL, NUL);
         7'd49:   r = mk("h", NUL, NUL);
         7'd50:   r = mk("8", NUL, NUL);
         7'd51:   r = mk("i", NUL, NUL);
         7'd52:   r = mk("k", NUL, NUL);
         7'd53:   r = mk("l", NUL, NUL);
         7'd54:   r = mk("m", NUL, NUL);
         7'd55:   r = mk("n", NUL, NUL);
         7'd56:   r = mk("k", "s", NUL);
         7'd57:   r = mk("o", NUL, NUL);
         7'd58:   r = mk("p", NUL, NUL);
         7'd59:   r = mk("r", NUL, NUL);
         7'd60:   r = mk("s", NUL, NUL);
         7'd61:   r = mk("s", NUL, NUL);
         7'd62:   r = mk("t", NUL, NUL);
         7'd63:   r = mk("u", NUL, NUL);
         7'd64:   r = mk("f", NUL, NUL);
         7'd65:   r = mk("x", NUL, NUL);
         7'd66:   r = mk("p", "s", NUL);
         7'd67:   r = mk("w", NUL, NUL);
         7'd68:   r = mk("i", "\"", NUL);
         7'd69:   r = mk("u", "\"", NUL);
         7'd70:   r = mk("o", "'", NUL);
         7'd71:   r = mk("u", "'", NUL);
         7'd72:   r = mk("w", "'", NUL);
         default: r = mk(NUL, NUL, NUL);
      endcase
      return r;
   endfunction

   function automatic map_type map_byte(input logic [7:0] b);
      map_type         m;
      logic [7:0]      row;
      row_type         r;
      row = b - 8'(FIRST_MAPPED);
      r   = row_chars(row[ROW_W-1:0]);
      if (b < 8'(FIRST_MAPPED)) begin
         m.chars = mk(b, NUL, NUL);
         m.cnt   = MCNT_W'(1);
      end else if (row >= 8'(TABLE_ROWS)) begin
         m.chars = r;
         m.cnt   = '0;
      end else begin
         m.chars = r;
         if (r[0] == NUL) m.cnt = MCNT_W'(0);
         else if (r[1] == NUL) m.cnt = MCNT_W'(1);
         else if (r[2] == NUL) m.cnt = MCNT_W'(2);
         else m.cnt = MCNT_W'(3);
      end
      return m;
   endfunction

   function automatic logic holdable(input logic [7:0] b);
      return b == CAP_M || b == CAP_N || b == SML_M || b == SML_N;
   endfunction

endpackage

// ===== hw/rtl/gtl_front.sv =====
module gtl_front
   import gtl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] in_byte,
   input  logic       end_of_input,
   output logic       push,
   output entry_type  push_entry
);

   logic       held_valid_ff, held_valid_in;
   logic [7:0] held_byte_ff, held_byte_in;

   logic       pre_en;
   logic [7:0] pre_char;
   logic       map_en;
   logic       is_t, is_p;
   map_type    held_map, new_map;
   logic [MCNT_W-1:0] mcnt;

   always_comb begin
      held_map      = map_byte(held_byte_ff);
      new_map       = map_byte(in_byte);
      is_t          = in_byte == CAP_T || in_byte == SML_T;
      is_p          = in_byte == CAP_P || in_byte == SML_P;
      pre_en        = 1'b0;
      pre_char      = held_map.chars[0];
      map_en        = 1'b0;
      held_valid_in = 1'b0;
      held_byte_in  = '0;

      if (end_of_input) begin
         pre_en = held_valid_ff;
      end else if (held_valid_ff) begin
         pre_en = 1'b1;
         if (is_t && (held_byte_ff == CAP_N || held_byte_ff == SML_N)) begin
            pre_char = (held_byte_ff == CAP_N) ? "D" : "d";
         end else if (is_p && (held_byte_ff == CAP_M || held_byte_ff == SML_M)) begin
            pre_char = (held_byte_ff == CAP_M) ? "B" : "b";
         end else if (is_t || is_p) begin
            map_en = 1'b1;
         end else if (holdable(in_byte)) begin
            held_valid_in = 1'b1;
            held_byte_in  = in_byte;
         end else begin
            map_en = 1'b1;
         end
      end else if (holdable(in_byte)) begin
         held_valid_in = 1'b1;
         held_byte_in  = in_byte;
      end else begin
         map_en = 1'b1;
      end

      mcnt = map_en ? new_map.cnt : '0;

      // Put the flushed letter ahead of the new byte's characters.
      if (pre_en) begin
         push_entry.chars = {new_map.chars, pre_char};
         push_entry.cnt   = CNT_W'(mcnt) + CNT_W'(1);
      end else begin
         push_entry.chars = {NUL, new_map.chars};
         push_entry.cnt   = CNT_W'(mcnt);
      end
      push = accept && (push_entry.cnt != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         held_byte_ff  <= '0;
      end else if (accept) begin
         held_valid_ff <= held_valid_in;
         held_byte_ff  <= held_byte_in;
      end
   end

endmodule

// ===== hw/rtl/gtl_queue.sv =====
module gtl_queue
   import gtl_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output head_type  head,
   output logic      full
);

   entry_type          slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]  count_ff;

   assign full       = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign head.valid = count_ff != '0;
   assign head.entry = slots_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         count_ff <= count_ff + QCNT_W'(push) - QCNT_W'(pop);
      end
   end

endmodule

// ===== hw/rtl/gtl_back.sv =====
module gtl_back
   import gtl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  head_type   head,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last_of_run
);

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             valid_ff, valid_in;
   logic [7:0]       char_ff, char_in;
   logic             last_ff, last_in;
   logic             advance;

   always_comb begin
      advance  = !valid_ff || !rsp_stall;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      if (advance) begin
         valid_in = head.valid;
         char_in  = head.entry.chars[idx_ff];
         last_in  = CNT_W'(idx_ff) + CNT_W'(1) == head.entry.cnt;
         if (head.valid) begin
            // Drop the entry once its final character is loaded.
            pop    = last_in;
            idx_in = last_in ? '0 : idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_char    = char_ff;
   assign rsp_last_of_run = last_ff;

endmodule

// ===== hw/rtl/greek_to_latin_transliterator.sv =====
// The first character of an accepted item is written to a queue slot, then to the output register.
// Throughput: one item accepted per cycle while the 4-entry queue has room; results
// leave at one character per cycle while rsp_stall is low; an item yields up to 4
// characters, one that yields none is not queued, and the output register holds one.
// Reset (synchronous, active high) clears the held letter, the queue and the output.
module greek_to_latin_transliterator
   import gtl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_input,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last_of_run
);

   logic      accept;
   logic      push;
   logic      pop;
   logic      full;
   entry_type push_entry;
   head_type  head;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   gtl_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .in_byte      (req_in_byte),
      .end_of_input (req_end_of_input),
      .push         (push),
      .push_entry   (push_entry)
   );

   gtl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .full       (full)
   );

   gtl_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_char    (rsp_out_char),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// ===== bench/greek_to_latin_transliterator_tb.sv =====
module greek_to_latin_transliterator_tb;
   import gtl_pkg::*;

   localparam int  RANDOM_ITEMS = 146;
   localparam int  QUIET_LIMIT  = 2000;
   localparam int  SHOWN_ERRORS = 10;
   localparam bit  TYPED        = 1'b1;
   localparam bit  PREDICTED    = 1'b0;

   typedef struct {
      logic [7:0] code;
      logic       eoi;
      bit         typed;
      string      text;
   } stim_type;

   typedef struct {
      logic [7:0] ch;
      logic       last;
   } latin_char_type;

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte      = 8'h00;
   logic       req_end_of_input = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall        = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_last_of_run;

   // no stalls or gaps on either side while set
   logic       calm = 1'b0;

   logic           nasal_held = 1'b0;
   logic [7:0]     nasal_byte = 8'h00;
   logic [7:0]     run_chars[$];
   latin_char_type expected_chars[$];
   int             char_errors  = 0;
   int             quiet_cycles = 0;

   string latin_rows [TABLE_ROWS] = '{
      "'A", "", "'E", "'H", "'I", "", "'O", "", "'Y", "'W",
      "i\"'",
      "A", "V", "G", "D", "E", "Z", "H", "8", "I", "K", "L", "M",
      "N", "KS", "O", "P", "R", "", "S", "T", "Y", "F", "X", "PS",
      "W", "", "",
      "a'", "e'", "h'", "i'", "u\"'",
      "a", "v", "g", "d", "e", "z", "h", "8", "i", "k", "l", "m",
      "n", "ks", "o", "p", "r", "s", "s", "t", "u", "f", "x", "ps",
      "w",
      "i\"", "u\"", "o'", "u'", "w'"
   };

   stim_type directed [] = '{
      '{8'h5A, 1'b1, TYPED, ""},        // end mark, nothing held
      '{8'h00, 1'b0, PREDICTED, ""},
      '{8'h41, 1'b0, TYPED, "A"},
      '{8'd181, 1'b0, PREDICTED, ""},
      '{8'd182, 1'b0, TYPED, "'A"},
      '{8'd183, 1'b0, TYPED, ""},       // empty row
      '{8'd192, 1'b0, TYPED, "i\"'"},
      '{8'd254, 1'b0, TYPED, "w'"},
      '{8'd255, 1'b0, TYPED, ""},       // past the table
      '{CAP_M, 1'b0, TYPED, ""},
      '{CAP_P, 1'b0, TYPED, "B"},
      '{SML_M, 1'b0, TYPED, ""},
      '{SML_P, 1'b0, TYPED, "b"},
      '{CAP_N, 1'b0, TYPED, ""},
      '{CAP_T, 1'b0, TYPED, "D"},
      '{SML_N, 1'b0, TYPED, ""},
      '{SML_T, 1'b0, TYPED, "d"},
      '{CAP_M, 1'b0, TYPED, ""},
      '{CAP_T, 1'b0, TYPED, "MT"},      // crossed pair
      '{CAP_N, 1'b0, TYPED, ""},
      '{SML_M, 1'b0, TYPED, "N"},       // flush N, hold m
      '{8'h41, 1'b0, TYPED, "mA"},
      '{CAP_M, 1'b0, TYPED, ""},
      '{8'hFF, 1'b1, TYPED, "M"}        // end mark flushes the hold
   };

   greek_to_latin_transliterator uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_end_of_input(req_end_of_input),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_char    (rsp_out_char),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always #5 clock = ~clock;

   function automatic bit is_nasal(input logic [7:0] b);
      return b == CAP_M || b == CAP_N || b == SML_M || b == SML_N;
   endfunction

   function automatic void emit_mapped(input logic [7:0] b);
      int unsigned row;
      if (b < 8'(FIRST_MAPPED)) begin
         run_chars.push_back(b);
         return;
      end
      row = int'(b) - FIRST_MAPPED;
      if (row >= TABLE_ROWS) return;
      for (int k = 0; k < latin_rows[row].len(); k++)
         run_chars.push_back(latin_rows[row][k]);
   endfunction

   // Fill run_chars with the characters one item yields and advance the hold.
   function automatic void transliterate(input logic [7:0] b, input logic eoi);
      logic [7:0] h;
      run_chars.delete();
      if (eoi) begin
         if (nasal_held) emit_mapped(nasal_byte);
         nasal_held = 1'b0;
         nasal_byte = 8'h00;
      end else if (nasal_held) begin
         h = nasal_byte;
         nasal_held = 1'b0;
         nasal_byte = 8'h00;
         if ((b == CAP_T || b == SML_T) && (h == CAP_N || h == SML_N)) begin
            run_chars.push_back(h == CAP_N ? "D" : "d");
         end else if ((b == CAP_P || b == SML_P) && (h == CAP_M || h == SML_M)) begin
            run_chars.push_back(h == CAP_M ? "B" : "b");
         end else if (b == CAP_T || b == SML_T || b == CAP_P || b == SML_P) begin
            emit_mapped(h);
            emit_mapped(b);
         end else begin
            emit_mapped(h);
            if (is_nasal(b)) begin
               nasal_held = 1'b1;
               nasal_byte = b;
            end else begin
               emit_mapped(b);
            end
         end
      end else if (is_nasal(b)) begin
         nasal_held = 1'b1;
         nasal_byte = b;
      end else begin
         emit_mapped(b);
      end
   endfunction

   function automatic void note_mismatch(input string msg);
      char_errors++;
      if (char_errors <= SHOWN_ERRORS) $display("%s", msg);
   endfunction

   // Offer one item, hold it until taken, then queue what it yields.
   task automatic send_item(input logic [7:0] b, input logic eoi, input bit typed,
                            input string text);
      latin_char_type c;
      while (!calm && $urandom_range(99) < 17) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_in_byte      <= b;
      req_end_of_input <= eoi;
      do @(posedge clock); while (req_stall);
      transliterate(b, eoi);
      if (typed) begin
         run_chars.delete();
         for (int k = 0; k < text.len(); k++) run_chars.push_back(text[k]);
      end
      foreach (run_chars[k]) begin
         c.ch   = run_chars[k];
         c.last = (k == run_chars.size() - 1);
         expected_chars.push_back(c);
      end
   endtask

   task automatic drain_output();
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
   endtask

   task automatic pick_random(output logic [7:0] b, output logic eoi);
      int unsigned sel;
      sel = $urandom_range(99);
      eoi = 1'b0;
      if (sel < 25) begin
         case ($urandom_range(3))
            0:       b = CAP_M;
            1:       b = CAP_N;
            2:       b = SML_M;
            default: b = SML_N;
         endcase
      end else if (sel < 40) begin
         case ($urandom_range(3))
            0:       b = CAP_P;
            1:       b = CAP_T;
            2:       b = SML_P;
            default: b = SML_T;
         endcase
      end else if (sel < 75) begin
         b = 8'($urandom_range(255, FIRST_MAPPED));
      end else if (sel < 91) begin
         b = 8'($urandom_range(FIRST_MAPPED - 1, 0));
      end else begin
         b   = 8'($urandom);
         eoi = 1'b1;
      end
   endtask

   always @(posedge clock) begin
      logic           moved;
      latin_char_type want;
      moved = !reset && req_valid && !req_stall;
      if (!reset && rsp_valid && !rsp_stall) begin
         moved = 1'b1;
         if (expected_chars.size() == 0) begin
            note_mismatch($sformatf("unexpected char %h last %b",
                                    rsp_out_char, rsp_last_of_run));
         end else begin
            want = expected_chars.pop_front();
            if (rsp_out_char !== want.ch || rsp_last_of_run !== want.last)
               note_mismatch($sformatf("expected char %h last %b, got char %h last %b",
                                       want.ch, want.last, rsp_out_char,
                                       rsp_last_of_run));
         end
      end
      rsp_stall    <= !calm && ($urandom_range(99) < 17);
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("greek_to_latin_transliterator_tb: done, errors");
         $finish;
      end
   end

   initial begin
      logic [7:0] b;
      logic       eoi;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i])
         send_item(directed[i].code, directed[i].eoi, directed[i].typed, directed[i].text);
      drain_output();
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         calm <= (i >= 60 && i < 110);
         if (i == 130) drain_output();
         pick_random(b, eoi);
         send_item(b, eoi, PREDICTED, "");
      end
      drain_output();
      repeat (8) @(posedge clock);
      if (char_errors == 0 && expected_chars.size() == 0)
         $display("greek_to_latin_transliterator_tb: done, clean");
      else
         $display("greek_to_latin_transliterator_tb: done, errors");
      $finish;
   end

endmodule
